// ===== design/pbps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbps_pkg: shared types and constants of the beep pattern sequencer
// Beat payloads, configuration set, step length lookups.
// ----------------------------------------------------------------------------
package pbps_pkg;

  // request codes
  localparam logic [1:0] REQ_POLL  = 2'd0;
  localparam logic [1:0] REQ_ALERT = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // priority codes
  localparam logic [1:0] PRIO_LOW      = 2'd0;
  localparam logic [1:0] PRIO_MEDIUM   = 2'd1;
  localparam logic [1:0] PRIO_HIGH     = 2'd2;
  localparam logic [1:0] PRIO_CRITICAL = 2'd3;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STOP  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [2:0] CFG_ALERTS_ENABLED    = 3'd0;
  localparam logic [2:0] CFG_SHORT_BEEP_TICKS  = 3'd1;
  localparam logic [2:0] CFG_LONG_BEEP_TICKS   = 3'd2;
  localparam logic [2:0] CFG_BEEP_GAP_TICKS    = 3'd3;
  localparam logic [2:0] CFG_LETTER_GAP_TICKS  = 3'd4;
  localparam logic [2:0] CFG_ONESHOT_LAST_STEP = 3'd5;
  localparam logic [2:0] CFG_PATTERN_STEPS     = 3'd6;

  localparam int unsigned CFG_DATA_BITS = 16;

  // gate decay and special steps
  localparam logic [15:0] DECAY_TICKS   = 16'd500;
  localparam logic [4:0]  LONG_STEP_A   = 5'd6;
  localparam logic [4:0]  LONG_STEP_B   = 5'd8;
  localparam logic [4:0]  LONG_STEP_C   = 5'd10;
  localparam logic [4:0]  LONG_STEP_D   = 5'd12;
  localparam logic [4:0]  LETTER_STEP_A = 5'd5;
  localparam logic [4:0]  LETTER_STEP_B = 5'd11;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ticks;
    logic [1:0]  alert_priority;
    logic [15:0] tone_hz;
    logic [23:0] rate_hz;
    logic [15:0] single_ticks;
  } req_t;

  typedef struct packed {
    logic        command;
    logic [15:0] beep_hz;
    logic [23:0] beep_rate;
    logic [15:0] beep_ticks;
    logic        looping;
    logic        last_of_run;
  } beep_t;

  typedef struct packed {
    logic        alerts_enabled;
    logic [15:0] short_beep_ticks;
    logic [15:0] long_beep_ticks;
    logic [15:0] beep_gap_ticks;
    logic [15:0] letter_gap_ticks;
    logic [4:0]  oneshot_last_step;
    logic [4:0]  pattern_steps;
  } cfg_t;

  // results of one item handed to the output queue
  typedef struct packed {
    logic [1:0] count;
    beep_t      b0;
    beep_t      b1;
  } push_t;

  function automatic logic [15:0] beep_length(input logic [4:0] step, input cfg_t cfg);
    if (step == LONG_STEP_A || step == LONG_STEP_B ||
        step == LONG_STEP_C || step == LONG_STEP_D) begin
      return cfg.long_beep_ticks;
    end
    return cfg.short_beep_ticks;
  endfunction

  function automatic logic [15:0] step_length(input logic [4:0] step, input cfg_t cfg);
    if (!step[0]) begin
      return beep_length(step, cfg);
    end
    if (step == LETTER_STEP_A || step == LETTER_STEP_B) begin
      return cfg.letter_gap_ticks;
    end
    return cfg.beep_gap_ticks;
  endfunction

endpackage
`default_nettype wire

// ===== design/pbps_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbps_req_if: request channel
// Valid/ready channel carrying one timestamped event per beat.
// ----------------------------------------------------------------------------
interface pbps_req_if;
  logic            valid;
  logic            ready;
  pbps_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/pbps_beep_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbps_beep_if: beep command channel
// Valid/ready channel carrying one beep start or stop command per beat.
// ----------------------------------------------------------------------------
interface pbps_beep_if;
  logic             valid;
  logic             ready;
  pbps_pkg::beep_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/pbps_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbps_cfg: configuration register file
// Write-only registers addressed by index, reset to their defaults.
// ----------------------------------------------------------------------------
module pbps_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [pbps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [pbps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output pbps_pkg::cfg_t                           cfg
);

  // hold register values, load on write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alerts_enabled    <= 1'b1;
      cfg.short_beep_ticks  <= 16'd100;
      cfg.long_beep_ticks   <= 16'd300;
      cfg.beep_gap_ticks    <= 16'd100;
      cfg.letter_gap_ticks  <= 16'd300;
      cfg.oneshot_last_step <= 5'd4;
      cfg.pattern_steps     <= 5'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        pbps_pkg::CFG_ALERTS_ENABLED:    cfg.alerts_enabled    <= cfg_data[0];
        pbps_pkg::CFG_SHORT_BEEP_TICKS:  cfg.short_beep_ticks  <= cfg_data;
        pbps_pkg::CFG_LONG_BEEP_TICKS:   cfg.long_beep_ticks   <= cfg_data;
        pbps_pkg::CFG_BEEP_GAP_TICKS:    cfg.beep_gap_ticks    <= cfg_data;
        pbps_pkg::CFG_LETTER_GAP_TICKS:  cfg.letter_gap_ticks  <= cfg_data;
        pbps_pkg::CFG_ONESHOT_LAST_STEP: cfg.oneshot_last_step <= cfg_data[4:0];
        pbps_pkg::CFG_PATTERN_STEPS:     cfg.pattern_steps     <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/pbps_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbps_core: event register and sequencer state
// Registers one event, then decides its beep commands and updates the
// pattern and priority gate state once the output queue has room.
// ----------------------------------------------------------------------------
module pbps_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  pbps_req_if.sink             req,
  input  wire pbps_pkg::cfg_t  cfg,
  input  wire logic            push_ok,
  output pbps_pkg::push_t      push
);

  // input register
  logic            s0_valid;
  pbps_pkg::req_t  s0;
  logic            fire;

  // sequencer state
  logic                 pattern_active;
  logic                 pattern_looping;
  logic [4:0]           step_index;
  logic [TIME_BITS-1:0] step_start_time;
  logic [1:0]           gate_priority;
  logic [TIME_BITS-1:0] last_alert_time;
  logic [15:0]          pattern_hz;
  logic [23:0]          pattern_rate;

  logic                 pattern_active_next;
  logic                 pattern_looping_next;
  logic [4:0]           step_index_next;
  logic [TIME_BITS-1:0] step_start_time_next;
  logic [1:0]           gate_priority_next;
  logic [TIME_BITS-1:0] last_alert_time_next;
  logic [15:0]          pattern_hz_next;
  logic [23:0]          pattern_rate_next;

  logic [63:0]          now_w;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] step_elapsed;
  logic [TIME_BITS-1:0] alert_elapsed;
  logic [4:0]           step_inc;
  logic [4:0]           step_wrap;
  logic [1:0]           gate_eff;
  logic [1:0]           n_res;
  pbps_pkg::beep_t      r0;
  pbps_pkg::beep_t      r1;
  logic                 loop_flag;

  assign req.ready = !s0_valid || push_ok;
  assign fire      = s0_valid && push_ok;

  // capture an event beat, drop it once processed
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s0_valid <= 1'b1;
    end else if (fire) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s0 <= req.data;
    end
  end

  // timestamps modulo 2^TIME_BITS
  assign now_w         = {32'b0, s0.now_ticks};
  assign now_t         = now_w[TIME_BITS-1:0];
  assign step_elapsed  = now_t - step_start_time;
  assign alert_elapsed = now_t - last_alert_time;
  assign step_inc      = step_index + 5'd1;
  assign step_wrap     = (step_inc >= cfg.pattern_steps) ? 5'd0 : step_inc;
  assign gate_eff      = (gate_priority != pbps_pkg::PRIO_LOW &&
                          alert_elapsed > TIME_BITS'(pbps_pkg::DECAY_TICKS)) ?
                         pbps_pkg::PRIO_LOW : gate_priority;

  // decide results and next state
  always_comb begin
    logic do_start;
    logic start_loop;
    do_start   = 1'b0;
    start_loop = 1'b0;

    pattern_active_next  = pattern_active;
    pattern_looping_next = pattern_looping;
    step_index_next      = step_index;
    step_start_time_next = step_start_time;
    gate_priority_next   = gate_priority;
    last_alert_time_next = last_alert_time;
    pattern_hz_next      = pattern_hz;
    pattern_rate_next    = pattern_rate;

    n_res = 2'd0;
    r0    = '0;
    r1    = '0;

    case (s0.req_type)
      pbps_pkg::REQ_POLL: begin
        if (pattern_active &&
            step_elapsed >= TIME_BITS'(pbps_pkg::step_length(step_index, cfg))) begin
          step_start_time_next = now_t;
          if (!pattern_looping && step_inc > cfg.oneshot_last_step) begin
            pattern_active_next = 1'b0;
            step_index_next     = step_inc;
          end else begin
            step_index_next = step_wrap;
            if (!step_wrap[0]) begin
              n_res         = 2'd1;
              r0.command    = pbps_pkg::CMD_START;
              r0.beep_hz    = pattern_hz;
              r0.beep_rate  = pattern_rate;
              r0.beep_ticks = pbps_pkg::beep_length(step_wrap, cfg);
            end
          end
        end
      end
      pbps_pkg::REQ_ALERT: begin
        if (cfg.alerts_enabled) begin
          if (pattern_active) begin
            if (s0.alert_priority == pbps_pkg::PRIO_CRITICAL) begin
              // preempt: stop the running pattern, then restart looping
              n_res              = 2'd1;
              r0.command         = pbps_pkg::CMD_STOP;
              gate_priority_next = pbps_pkg::PRIO_CRITICAL;
              do_start           = 1'b1;
              start_loop         = 1'b1;
            end
          end else begin
            gate_priority_next = gate_eff;
            case (s0.alert_priority)
              pbps_pkg::PRIO_LOW: begin
                if (gate_eff == pbps_pkg::PRIO_LOW) begin
                  last_alert_time_next = now_t;
                  n_res         = 2'd1;
                  r0.command    = pbps_pkg::CMD_START;
                  r0.beep_hz    = s0.tone_hz;
                  r0.beep_rate  = s0.rate_hz;
                  r0.beep_ticks = s0.single_ticks;
                end
              end
              pbps_pkg::PRIO_CRITICAL: begin
                gate_priority_next = pbps_pkg::PRIO_CRITICAL;
                do_start           = 1'b1;
                start_loop         = 1'b1;
              end
              pbps_pkg::PRIO_HIGH: begin
                if (gate_eff < pbps_pkg::PRIO_HIGH) begin
                  gate_priority_next = pbps_pkg::PRIO_HIGH;
                  do_start           = 1'b1;
                  start_loop         = 1'b1;
                end
              end
              default: begin
                if (gate_eff < pbps_pkg::PRIO_HIGH) begin
                  gate_priority_next = pbps_pkg::PRIO_MEDIUM;
                  do_start           = 1'b1;
                end
              end
            endcase
          end
        end
      end
      pbps_pkg::REQ_STOP: begin
        n_res               = 2'd1;
        r0.command          = pbps_pkg::CMD_STOP;
        pattern_active_next = 1'b0;
        step_index_next     = 5'd0;
        gate_priority_next  = pbps_pkg::PRIO_LOW;
      end
      default: begin
      end
    endcase

    // start a pattern: first beep goes after any preempt stop
    if (do_start) begin
      last_alert_time_next = now_t;
      pattern_active_next  = 1'b1;
      pattern_looping_next = start_loop;
      pattern_hz_next      = s0.tone_hz;
      pattern_rate_next    = s0.rate_hz;
      step_index_next      = 5'd0;
      step_start_time_next = now_t;
      if (n_res == 2'd1) begin
        n_res         = 2'd2;
        r1.command    = pbps_pkg::CMD_START;
        r1.beep_hz    = s0.tone_hz;
        r1.beep_rate  = s0.rate_hz;
        r1.beep_ticks = cfg.short_beep_ticks;
      end else begin
        n_res         = 2'd1;
        r0.command    = pbps_pkg::CMD_START;
        r0.beep_hz    = s0.tone_hz;
        r0.beep_rate  = s0.rate_hz;
        r0.beep_ticks = cfg.short_beep_ticks;
      end
    end

    // tag flags known only after the state update
    loop_flag      = pattern_active_next && pattern_looping_next;
    r0.looping     = loop_flag;
    r1.looping     = loop_flag;
    r0.last_of_run = (n_res == 2'd1);
    r1.last_of_run = 1'b1;
  end

  assign push.count = fire ? n_res : 2'd0;
  assign push.b0    = r0;
  assign push.b1    = r1;

  // advance state on a processed event
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_active  <= 1'b0;
      pattern_looping <= 1'b0;
      step_index      <= 5'd0;
      step_start_time <= '0;
      gate_priority   <= pbps_pkg::PRIO_LOW;
      last_alert_time <= '0;
      pattern_hz      <= 16'd0;
      pattern_rate    <= 24'd0;
    end else if (fire) begin
      pattern_active  <= pattern_active_next;
      pattern_looping <= pattern_looping_next;
      step_index      <= step_index_next;
      step_start_time <= step_start_time_next;
      gate_priority   <= gate_priority_next;
      last_alert_time <= last_alert_time_next;
      pattern_hz      <= pattern_hz_next;
      pattern_rate    <= pattern_rate_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/pbps_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbps_outq: beep command queue
// Four-entry queue taking up to two commands per cycle and handing out one
// beat per cycle while beep.ready is high.
// ----------------------------------------------------------------------------
module pbps_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pbps_pkg::push_t  push,
  output logic                  push_ok,
  pbps_beep_if.source           beep
);

  localparam int unsigned DEPTH = 4;

  pbps_pkg::beep_t mem [DEPTH];
  logic [1:0]      wr_ptr;
  logic [1:0]      rd_ptr;
  logic [2:0]      count;
  logic [1:0]      wr_ptr_b;
  logic            pop;

  // room for a two-command item
  assign push_ok    = (count <= 3'(DEPTH - 2));
  assign beep.valid = (count != 3'd0);
  assign beep.data  = mem[rd_ptr];
  assign pop        = beep.valid && beep.ready;
  assign wr_ptr_b   = wr_ptr + 2'd1;

  // store pushed commands
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.b0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_b] <= push.b1;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push.count} - {2'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== design/priority_beep_pattern_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// priority_beep_pattern_sequencer: priority-gated beep pattern sequencer
// Path: an accepted event beat is registered in the core, then its commands are
// written to the queue, which hands them out. Throughput: one event per cycle
// while the queue has room; a critical preempt pushes two commands, a stop
// then a start. Reset: synchronous, clears the pattern, gate, queue and
// configuration to defaults; events are accepted once reset is released.
// ----------------------------------------------------------------------------
module priority_beep_pattern_sequencer #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  pbps_req_if.sink                                 req,
  pbps_beep_if.source                              beep,
  input  wire logic                                cfg_we,
  input  wire logic [pbps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [pbps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  pbps_pkg::cfg_t  cfg;
  pbps_pkg::push_t push;
  logic            push_ok;

  pbps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbps_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg     (cfg),
    .push_ok (push_ok),
    .push    (push)
  );

  pbps_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_ok (push_ok),
    .beep    (beep)
  );

  // commands are only pushed when the queue has room for two
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> push_ok)
    else $error("push without queue room");

  // a two-command item is a preempt: stop, then start
  a_preempt_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.b0.command == pbps_pkg::CMD_STOP &&
                           push.b1.command == pbps_pkg::CMD_START &&
                           !push.b0.last_of_run && push.b1.last_of_run)
    else $error("bad preempt command pair");

  // a single command closes its run
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd1 |-> push.b0.last_of_run)
    else $error("single command not marked last");

  // a stop command carries no tone
  a_stop_clean: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 && push.b0.command == pbps_pkg::CMD_STOP |->
      push.b0.beep_hz == 16'd0 && push.b0.beep_ticks == 16'd0)
    else $error("stop command with tone fields");

endmodule
`default_nettype wire
